// ----- rtl/reversible_fifo_with_peek_defines.svh -----
// Assertion macros for the reversible queue checker.
`ifndef REVERSIBLE_FIFO_WITH_PEEK_DEFINES_SVH
`define REVERSIBLE_FIFO_WITH_PEEK_DEFINES_SVH

// Immediate implication checked at every edge outside reset.
`define RFWP_ASSERT_IMPL(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// Implication checked in the cycle after the condition, outside reset.
`define RFWP_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

// ----- rtl/rfwp_pkg.sv -----
// Shared command codes, status codes and result types for the reversible queue.
`timescale 1ns / 1ps

package rfwp_pkg;

  // Command codes carried on the input selector
  localparam logic [2:0] CMD_ENQ   = 3'd0;
  localparam logic [2:0] CMD_DEQ   = 3'd1;
  localparam logic [2:0] CMD_PEEK  = 3'd2;
  localparam logic [2:0] CMD_CLEAR = 3'd3;
  localparam logic [2:0] CMD_REV   = 3'd4;

  // Status codes returned with each result
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  // Fixed field widths on the ports
  localparam int CMD_W   = 3;
  localparam int VALUE_W = 32;
  localparam int POS_W   = 8;
  localparam int COUNT_W = 9;

  // Per-item result information from the controller
  typedef struct packed {
    logic [1:0] status;
    logic       rd_sel;
  } rfwp_res_t;

endpackage

// ----- rtl/rfwp_ram.sv -----
// Ring storage: one write port and one registered read port.
`timescale 1ns / 1ps

module rfwp_ram
  import rfwp_pkg::*;
#(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int DW    = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic          re,
  input  logic [AW-1:0] addr,
  input  logic [DW-1:0] wdata,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  // Write the entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  // Register the read word; hold it between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ----- rtl/rfwp_ctrl.sv -----
// Queue controller: pointers, fill count, direction flag and command decode.
`timescale 1ns / 1ps

module rfwp_ctrl
  import rfwp_pkg::*;
#(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int CW    = 9,
  parameter int DW    = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic [CMD_W-1:0]   command,
  input  logic [VALUE_W-1:0] push_value,
  input  logic [POS_W-1:0]   position,
  output logic               mem_we,
  output logic               mem_re,
  output logic [AW-1:0]      mem_addr,
  output logic [DW-1:0]      mem_wdata,
  output rfwp_res_t          res,
  output logic [CW-1:0]      count_next
);

  localparam int SW = ((AW > POS_W) ? AW : POS_W) + 2;

  logic [AW-1:0] head, head_next;
  logic [AW-1:0] tail, tail_next;
  logic [CW-1:0] count;
  logic          rev, rev_next;

  logic          full, empty, in_range;
  logic [AW-1:0] head_inc, head_dec, tail_dec, tail_inc;
  logic [SW-1:0] fwd_sum, rev_sum;
  logic [AW-1:0] fwd_idx, rev_idx;
  logic [63:0]   value_ext;

  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign in_range = (SW'(position) < SW'(count));

  assign head_inc = (head == AW'(DEPTH - 1)) ? '0 : head + 1'b1;
  assign head_dec = (head == '0) ? AW'(DEPTH - 1) : head - 1'b1;
  assign tail_inc = (tail == AW'(DEPTH - 1)) ? '0 : tail + 1'b1;
  assign tail_dec = (tail == '0) ? AW'(DEPTH - 1) : tail - 1'b1;

  // Peek index: front-relative offset, one wrap at most in either direction
  always_comb begin
    fwd_sum = SW'(head) + SW'(position);
    if (fwd_sum >= SW'(DEPTH)) begin
      fwd_sum = fwd_sum - SW'(DEPTH);
    end
    rev_sum = SW'(tail) + SW'(DEPTH - 1) - SW'(position);
    if (rev_sum >= SW'(DEPTH)) begin
      rev_sum = rev_sum - SW'(DEPTH);
    end
  end
  assign fwd_idx = fwd_sum[AW-1:0];
  assign rev_idx = rev_sum[AW-1:0];

  assign value_ext = 64'(push_value);
  assign mem_wdata = value_ext[DW-1:0];

  // Decode the command against the current state
  always_comb begin
    head_next  = head;
    tail_next  = tail;
    count_next = count;
    rev_next   = rev;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_addr   = head;
    res.status = ST_OK;
    res.rd_sel = 1'b0;
    unique case (command)
      CMD_ENQ: begin
        if (full) begin
          res.status = ST_FULL;
        end else if (!rev) begin
          mem_we     = accept;
          mem_addr   = tail;
          tail_next  = tail_inc;
          count_next = count + 1'b1;
        end else begin
          mem_we     = accept;
          mem_addr   = head_dec;
          head_next  = head_dec;
          count_next = count + 1'b1;
        end
      end
      CMD_DEQ: begin
        if (empty) begin
          res.status = ST_EMPTY;
        end else if (!rev) begin
          mem_re     = accept;
          mem_addr   = head;
          res.rd_sel = 1'b1;
          head_next  = head_inc;
          count_next = count - 1'b1;
        end else begin
          mem_re     = accept;
          mem_addr   = tail_dec;
          res.rd_sel = 1'b1;
          tail_next  = tail_dec;
          count_next = count - 1'b1;
        end
      end
      CMD_PEEK: begin
        if (!in_range) begin
          res.status = ST_RANGE;
        end else begin
          mem_re     = accept;
          mem_addr   = rev ? rev_idx : fwd_idx;
          res.rd_sel = 1'b1;
        end
      end
      CMD_CLEAR: begin
        head_next  = '0;
        tail_next  = '0;
        count_next = '0;
        rev_next   = 1'b0;
      end
      CMD_REV: begin
        rev_next = !rev;
      end
      default: begin
      end
    endcase
  end

  // Advance the queue state on each accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
      rev   <= 1'b0;
    end else if (accept) begin
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
      rev   <= rev_next;
    end
  end

endmodule

// ----- rtl/reversible_fifo_with_peek.sv -----
// Top level of the reversible queue with peek.
`timescale 1ns / 1ps

// Bounded queue of DATA_WIDTH-bit words in a DEPTH-entry ring.
// Input stream (s_*): one command per item, selected by s_tuser:
//   enqueue, dequeue, peek at a position from the front, clear, reverse.
// Output stream (m_*): exactly one result per command with the read word,
//   a status code (m_tuser), the element count and an empty flag.
// The result is registered and becomes valid in the cycle after the command is accepted.
// Throughput: one command per cycle unless the receiver stalls; the ring is
//   one memory with one write port and one registered read port, and each
//   command uses at most one of them, so pointers and count update at once.
// Reversal swaps the roles of the two ring ends; no data moves.
// Reset clears pointers, count and direction; the ring itself is not
//   cleared, since an entry is read only after it was written.
// When the receiver stalls, the result register holds its item and
//   s_tready drops until that item is taken; a result being taken in the
//   same cycle frees the register for the next command.
module reversible_fifo_with_peek
  import rfwp_pkg::*;
#(
  parameter int DEPTH      = 256,
  parameter int DATA_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,  // push_value[31:0], position[39:32]
  input  logic [2:0]  s_tuser,  // command[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,  // read_data[31:0], element_count[40:32],
                                // is_empty[41], zero[47:42]
  output logic [1:0]  m_tuser   // status[1:0]
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic                  accept;
  logic                  mem_we, mem_re;
  logic [AW-1:0]         mem_addr;
  logic [DATA_WIDTH-1:0] mem_wdata, mem_rdata;
  rfwp_res_t             res;
  logic [CW-1:0]         count_next;

  logic                  out_valid;
  logic                  rd_sel_q;
  logic [1:0]            status_q;
  logic [COUNT_W-1:0]    count_q;
  logic                  empty_q;
  logic [63:0]           rd_ext;
  logic [31:0]           count_ext;

  assign s_tready = !out_valid || m_tready;
  assign accept   = s_tvalid && s_tready;

  rfwp_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW),
    .DW    (DATA_WIDTH)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .command    (s_tuser),
    .push_value (s_tdata[31:0]),
    .position   (s_tdata[39:32]),
    .mem_we     (mem_we),
    .mem_re     (mem_re),
    .mem_addr   (mem_addr),
    .mem_wdata  (mem_wdata),
    .res        (res),
    .count_next (count_next)
  );

  rfwp_ram #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (DATA_WIDTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  assign count_ext = 32'(count_next);

  // Hold the result valid until the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  // Capture the result fields of the accepted item
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_sel_q <= res.rd_sel;
      status_q <= res.status;
      count_q  <= count_ext[COUNT_W-1:0];
      empty_q  <= (count_next == '0);
    end
  end

  assign rd_ext   = 64'(mem_rdata);
  assign m_tvalid = out_valid;
  assign m_tuser  = status_q;
  assign m_tdata  = {6'b0, empty_q, count_q, rd_sel_q ? rd_ext[31:0] : 32'b0};

endmodule

// ----- rtl/rfwp_checker.sv -----
// Port-level checker for the reversible queue, bound to the top level.
`timescale 1ns / 1ps
`include "reversible_fifo_with_peek_defines.svh"

module rfwp_checker
  import rfwp_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [2:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata,
  input logic [1:0]  m_tuser
);

  // Stalled result holds
  `RFWP_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready,
    m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

  // Empty flag agrees with the count
  `RFWP_ASSERT_IMPL(a_empty_flag, m_tvalid, m_tdata[41] == (m_tdata[40:32] == 9'd0),
    "empty flag disagrees with count")

  // Failed commands return zero data
  `RFWP_ASSERT_IMPL(a_fail_zero, m_tvalid && (m_tuser != ST_OK), m_tdata[31:0] == 32'd0,
    "failed command returned data")

  // Free result register means ready for a command
  `RFWP_ASSERT_IMPL(a_ready_free, !m_tvalid, s_tready, "not ready with empty result register")

  // An accepted clear reports an empty queue on the next cycle
  `RFWP_ASSERT_NEXT(a_clear_empty, s_tvalid && s_tready && (s_tuser == CMD_CLEAR),
    m_tvalid && (m_tuser == ST_OK) && m_tdata[41], "clear did not report an empty queue")

endmodule

bind reversible_fifo_with_peek rfwp_checker u_rfwp_checker (.*);

// ----- bench/reversible_fifo_with_peek_test.sv -----
// Self-checking testbench for the reversible queue with peek.
`timescale 1ns / 1ps

module reversible_fifo_with_peek_test;
  import rfwp_pkg::*;

  localparam int QDEPTH      = 256;
  localparam int N_PLAN      = 25;
  localparam int IDLE_LIMIT  = 2000;
  localparam int MAX_REPORTS = 10;

  // Spare command codes that the block treats as no-ops
  localparam logic [2:0] CMD_SPARE5 = 3'd5;
  localparam logic [2:0] CMD_SPARE6 = 3'd6;
  localparam logic [2:0] CMD_SPARE7 = 3'd7;

  typedef struct packed {
    logic [31:0] rd;
    logic [1:0]  status;
    logic [8:0]  count;
    logic        empty;
  } reply_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] value;
    logic [7:0]  pos;
    logic        known;
    reply_t      want;
  } plan_row_t;

  typedef enum {LOAD_UP, DRAIN_DOWN, MIXED} traffic_e;

  // Directed commands; rows with known set carry a typed-in reply
  localparam plan_row_t PLAN [N_PLAN] = '{
    '{CMD_DEQ,    32'h0,        8'h00, 1'b1, '{32'h0,        ST_EMPTY, 9'd0, 1'b1}},
    '{CMD_PEEK,   32'h0,        8'h00, 1'b1, '{32'h0,        ST_RANGE, 9'd0, 1'b1}},
    '{CMD_PEEK,   32'h0,        8'hFF, 1'b1, '{32'h0,        ST_RANGE, 9'd0, 1'b1}},
    '{CMD_REV,    32'h0,        8'h00, 1'b1, '{32'h0,        ST_OK,    9'd0, 1'b1}},
    '{CMD_ENQ,    32'hFFFFFFFF, 8'hFF, 1'b1, '{32'h0,        ST_OK,    9'd1, 1'b0}},
    '{CMD_ENQ,    32'h0,        8'h00, 1'b1, '{32'h0,        ST_OK,    9'd2, 1'b0}},
    '{CMD_PEEK,   32'h0,        8'h00, 1'b0, '0},
    '{CMD_PEEK,   32'h0,        8'h01, 1'b0, '0},
    '{CMD_PEEK,   32'h0,        8'h02, 1'b1, '{32'h0,        ST_RANGE, 9'd2, 1'b0}},
    '{CMD_REV,    32'h0,        8'h00, 1'b1, '{32'h0,        ST_OK,    9'd2, 1'b0}},
    '{CMD_ENQ,    32'hA5A5A5A5, 8'h00, 1'b1, '{32'h0,        ST_OK,    9'd3, 1'b0}},
    '{CMD_PEEK,   32'h0,        8'h02, 1'b0, '0},
    '{CMD_DEQ,    32'h0,        8'h00, 1'b0, '0},
    '{CMD_SPARE5, 32'hFFFFFFFF, 8'hFF, 1'b1, '{32'h0,        ST_OK,    9'd2, 1'b0}},
    '{CMD_SPARE6, 32'hFFFFFFFF, 8'hFF, 1'b1, '{32'h0,        ST_OK,    9'd2, 1'b0}},
    '{CMD_SPARE7, 32'hFFFFFFFF, 8'hFF, 1'b1, '{32'h0,        ST_OK,    9'd2, 1'b0}},
    '{CMD_CLEAR,  32'h0,        8'h00, 1'b1, '{32'h0,        ST_OK,    9'd0, 1'b1}},
    '{CMD_ENQ,    32'h12345678, 8'h00, 1'b1, '{32'h0,        ST_OK,    9'd1, 1'b0}},
    '{CMD_DEQ,    32'h0,        8'h00, 1'b1, '{32'h12345678, ST_OK,    9'd0, 1'b1}},
    '{CMD_DEQ,    32'h0,        8'h00, 1'b1, '{32'h0,        ST_EMPTY, 9'd0, 1'b1}},
    '{CMD_REV,    32'h0,        8'h00, 1'b1, '{32'h0,        ST_OK,    9'd0, 1'b1}},
    '{CMD_ENQ,    32'h5A5A5A5A, 8'h00, 1'b1, '{32'h0,        ST_OK,    9'd1, 1'b0}},
    '{CMD_PEEK,   32'h0,        8'h00, 1'b1, '{32'h5A5A5A5A, ST_OK,    9'd1, 1'b0}},
    '{CMD_DEQ,    32'h0,        8'h00, 1'b1, '{32'h5A5A5A5A, ST_OK,    9'd0, 1'b1}},
    '{CMD_CLEAR,  32'h0,        8'h00, 1'b1, '{32'h0,        ST_OK,    9'd0, 1'b1}}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;  // push_value[31:0], position[39:32]
  logic [2:0]  s_tuser = '0;  // command[2:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;       // read_data[31:0], element_count[40:32], is_empty[41]
  logic [1:0]  m_tuser;       // status[1:0]

  // Shadow queue state
  logic [31:0] q_mem [QDEPTH];
  logic [7:0]  q_head = '0;
  logic [7:0]  q_tail = '0;
  logic [8:0]  q_fill = '0;
  logic        q_backward = 1'b0;

  reply_t reply_q [$];
  int     mismatches = 0;
  int     burst_left = 0;
  bit     steady = 1'b0;

  reversible_fifo_with_peek u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Apply one command to the shadow queue and return its reply
  function automatic reply_t run_command(logic [2:0] cmd, logic [31:0] value,
                                         logic [7:0] pos);
    reply_t     r;
    logic [7:0] idx;
    r = '0;
    r.status = ST_OK;
    case (cmd)
      CMD_ENQ: begin
        if (q_fill == QDEPTH) begin
          r.status = ST_FULL;
        end else if (!q_backward) begin
          q_mem[q_tail] = value;
          q_tail = q_tail + 8'd1;
          q_fill = q_fill + 9'd1;
        end else begin
          q_head = q_head - 8'd1;
          q_mem[q_head] = value;
          q_fill = q_fill + 9'd1;
        end
      end
      CMD_DEQ: begin
        if (q_fill == 0) begin
          r.status = ST_EMPTY;
        end else if (!q_backward) begin
          r.rd = q_mem[q_head];
          q_head = q_head + 8'd1;
          q_fill = q_fill - 9'd1;
        end else begin
          q_tail = q_tail - 8'd1;
          r.rd = q_mem[q_tail];
          q_fill = q_fill - 9'd1;
        end
      end
      CMD_PEEK: begin
        if ({1'b0, pos} >= q_fill) begin
          r.status = ST_RANGE;
        end else begin
          // Count from whichever end is the front in the current direction
          idx = q_backward ? q_tail - 8'd1 - pos : q_head + pos;
          r.rd = q_mem[idx];
        end
      end
      CMD_CLEAR: begin
        q_head = '0;
        q_tail = '0;
        q_fill = '0;
        q_backward = 1'b0;
      end
      CMD_REV: begin
        q_backward = !q_backward;
      end
      default: begin
      end
    endcase
    r.count = q_fill;
    r.empty = (q_fill == 0);
    return r;
  endfunction

  // Offer one command, hold it until taken, then record its reply
  task automatic send_command(logic [2:0] cmd, logic [31:0] value, logic [7:0] pos,
                              logic known, reply_t want);
    reply_t predicted;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(7) == 0) steady = !steady;
      if (!steady) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {pos, value};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predicted = run_command(cmd, value, pos);
    reply_q.push_back(known ? want : predicted);
  endtask

  task automatic note_mismatch(string field, logic [31:0] want, logic [31:0] got);
    if (mismatches < MAX_REPORTS)
      $display("mismatch %s: expected %h, got %h", field, want, got);
    mismatches++;
  endtask

  // Compare each result against the oldest expected reply
  always @(posedge clk) begin
    reply_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (reply_q.size() == 0) begin
        note_mismatch("unexpected item", '0, m_tdata[31:0]);
      end else begin
        want = reply_q.pop_front();
        if (m_tdata[31:0] !== want.rd) note_mismatch("read_data", want.rd, m_tdata[31:0]);
        if (m_tuser !== want.status)
          note_mismatch("status", 32'(want.status), 32'(m_tuser));
        if (m_tdata[40:32] !== want.count)
          note_mismatch("element_count", 32'(want.count), 32'(m_tdata[40:32]));
        if (m_tdata[41] !== want.empty)
          note_mismatch("is_empty", 32'(want.empty), 32'(m_tdata[41]));
      end
    end
  end

  // Receiver back-pressure: one of four patterns, chosen at random and redrawn periodically
  int      rx_cycle = 0;
  int      rx_mode = 0;
  int      stall_left = 0;
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle % 64 == 0) rx_mode <= $urandom_range(3);
    case (rx_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= 1'($urandom_range(1));
      2: m_tready <= (rx_cycle % 4 != 0);
      default: begin
        if (stall_left > 0) begin
          stall_left <= stall_left - 1;
          m_tready <= 1'b0;
        end else if ($urandom_range(19) == 0) begin
          stall_left <= $urandom_range(10, 30);
          m_tready <= 1'b0;
        end else begin
          m_tready <= 1'b1;
        end
      end
    endcase
  end

  // Abort when neither side has moved an item for too long
  int idle_cycles = 0;
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("reversible_fifo_with_peek_test NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    traffic_e    phase_kind [4];
    int          phase_len [4];
    traffic_e    kind;
    logic [2:0]  cmd;
    logic [31:0] value;
    logic [7:0]  pos;
    int          r;
    int          k;
    phase_kind = '{MIXED, LOAD_UP, DRAIN_DOWN, MIXED};
    phase_len  = '{100, 320, 300, 100};

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed part
    for (int i = 0; i < N_PLAN; i++)
      send_command(PLAN[i].cmd, PLAN[i].value, PLAN[i].pos, PLAN[i].known, PLAN[i].want);

    // Random part: fill past full, drain past empty, mixed traffic around them
    for (int p = 0; p < 4; p++) begin
      kind = phase_kind[p];
      for (int n = 0; n < phase_len[p]; n++) begin
        r = $urandom_range(99);
        case (kind)
          LOAD_UP: cmd = (r < 92) ? CMD_ENQ : (r < 97) ? CMD_PEEK : (r < 99) ? CMD_REV :
                         3'($urandom_range(CMD_SPARE5, CMD_SPARE7));
          DRAIN_DOWN: cmd = (r < 90) ? CMD_DEQ : (r < 96) ? CMD_PEEK :
                            (r < 99) ? CMD_REV : CMD_ENQ;
          default: cmd = (r < 35) ? CMD_ENQ : (r < 65) ? CMD_DEQ : (r < 90) ? CMD_PEEK :
                         (r < 95) ? CMD_REV : (r < 98) ? CMD_CLEAR :
                         3'($urandom_range(CMD_SPARE5, CMD_SPARE7));
        endcase
        value = $urandom();
        pos = 8'($urandom());
        if (cmd == CMD_PEEK) begin
          // Mostly in range, sometimes right at the fill boundary
          k = $urandom_range(9);
          if (k < 7 && q_fill != 0) pos = 8'($urandom_range(int'(q_fill) - 1));
          else if (k < 9 && q_fill < QDEPTH) pos = q_fill[7:0];
        end
        send_command(cmd, value, pos, 1'b0, '0);
      end
    end
    s_tvalid <= 1'b0;

    // Drain outstanding replies, then allow for stray results
    while (reply_q.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (mismatches == 0) begin
      $display("reversible_fifo_with_peek_test OK");
    end else begin
      $display("reversible_fifo_with_peek_test NOT OK");
    end
    $finish;
  end

endmodule
